FILE: design/preamble_length_packet_deframer_macros.svh
// Assertion macros for the packet deframer.
// Used by the files that assert, expects clk_i and rst_ni in scope.
`ifndef PREAMBLE_LENGTH_PACKET_DEFRAMER_MACROS_SVH
`define PREAMBLE_LENGTH_PACKET_DEFRAMER_MACROS_SVH

// Check a property on every clock edge outside reset.
`define PLPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define PLPD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: design/plpd_pkg.sv
// Shared widths and constants of the packet deframer.
// No dependencies; used by the interfaces and the top level.
package plpd_pkg;

  localparam int BYTE_W     = 8;
  localparam int LEN_W      = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam int LENGTH_LIMIT = 1024;

  localparam logic [LEN_W-1:0] MAX_LEN_RESET =
    (LENGTH_LIMIT > 2047) ? 11'd2047 : LEN_W'(LENGTH_LIMIT);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PREAMBLE = 2'd0,
    CFG_TYPE     = 2'd1,
    CFG_MAX_LEN  = 2'd2
  } cfg_idx_e;

endpackage

FILE: design/plpd_rx_if.sv
// Received byte channel of the packet deframer.
// Depends on plpd_pkg.
interface plpd_rx_if import plpd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: design/plpd_res_if.sv
// Result channel of the packet deframer: payload bytes and packet marks.
// Depends on plpd_pkg.
interface plpd_res_if import plpd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] payload_byte;
  logic              first_of_packet;
  logic              last_of_packet;
  logic              empty_packet;

  modport source (output valid, output payload_byte, output first_of_packet,
                  output last_of_packet, output empty_packet, input ready);
  modport sink   (input valid, input payload_byte, input first_of_packet,
                  input last_of_packet, input empty_packet, output ready);
endinterface

FILE: design/preamble_length_packet_deframer.sv
// Preamble / type / length packet deframer, top level.
// Depends on plpd_pkg, plpd_rx_if, plpd_res_if and the assertion macros.
//
// Takes one received byte per clock cycle. A byte is taken whenever the
// result register is empty or is being drained in the same cycle, so with
// a ready sink the rate is one byte per cycle; the result of a byte shows
// in the cycle after it was taken. The single result register sets both
// the rate and that timing. Header rescan after a length error is resolved
// within the cycle of the failing length byte. No clearing pass after reset.
`include "preamble_length_packet_deframer_macros.svh"

module preamble_length_packet_deframer import plpd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  plpd_rx_if.sink               rx_i,
  plpd_res_if.source            res_o
);

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_TYPE    = 3'd1,
    PH_LEN_LO  = 3'd2,
    PH_LEN_HI  = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_e;

  logic [BYTE_W-1:0] preamble_q;
  logic [BYTE_W-1:0] acc_type_q;
  logic [LEN_W-1:0]  max_len_q;

  phase_e            phase_q, phase_d;
  logic [BYTE_W-1:0] held_type_q, held_type_d;
  logic [BYTE_W-1:0] held_len_lo_q, held_len_lo_d;
  logic [LEN_W-1:0]  remaining_q, remaining_d;
  logic              at_first_q, at_first_d;

  logic              res_valid_q, res_valid_d;
  logic [BYTE_W-1:0] res_byte_q, res_byte_d;
  logic              res_first_q, res_first_d;
  logic              res_last_q, res_last_d;
  logic              res_empty_q, res_empty_d;

  logic              rx_req;
  logic              res_load;
  logic [BYTE_W-1:0] b;
  logic [2*BYTE_W-1:0] len;
  logic [LEN_W-1:0]  limit;
  phase_e            scan;

  function automatic phase_e hunt_next(input logic [BYTE_W-1:0] v,
                                       input logic [BYTE_W-1:0] pre);
    return (v == pre) ? PH_TYPE : PH_HUNT;
  endfunction

  assign rx_i.ready = !res_valid_q || res_o.ready;
  assign rx_req     = rx_i.valid && rx_i.ready;
  assign b          = rx_i.rx_byte;
  assign len        = {b, held_len_lo_q};
  assign limit      = (max_len_q < MAX_LEN_RESET) ? max_len_q : MAX_LEN_RESET;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      preamble_q <= '0;
      acc_type_q <= '0;
      max_len_q  <= MAX_LEN_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PREAMBLE: preamble_q <= cfg_data_i[BYTE_W-1:0];
        CFG_TYPE:     acc_type_q <= cfg_data_i[BYTE_W-1:0];
        CFG_MAX_LEN:  max_len_q  <= cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_d       = phase_q;
    held_type_d   = held_type_q;
    held_len_lo_d = held_len_lo_q;
    remaining_d   = remaining_q;
    at_first_d    = at_first_q;
    res_load      = 1'b0;
    res_byte_d    = res_byte_q;
    res_first_d   = res_first_q;
    res_last_d    = res_last_q;
    res_empty_d   = res_empty_q;
    scan          = PH_HUNT;

    case (phase_q)
      PH_TYPE: begin
        if (b == acc_type_q) begin
          held_type_d = b;
          phase_d     = PH_LEN_LO;
        end else begin
          phase_d = hunt_next(b, preamble_q);
        end
      end
      PH_LEN_LO: begin
        held_len_lo_d = b;
        phase_d       = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        if (len > {{(2*BYTE_W-LEN_W){1'b0}}, limit}) begin
          // drop the preamble, rescan type, low length and this byte
          scan = hunt_next(held_type_q, preamble_q);
          if (scan == PH_TYPE && held_len_lo_q == acc_type_q) begin
            held_type_d = held_len_lo_q;
            scan        = PH_LEN_LO;
          end else begin
            scan = hunt_next(held_len_lo_q, preamble_q);
          end
          case (scan)
            PH_TYPE: begin
              if (b == acc_type_q) begin
                held_type_d = b;
                phase_d     = PH_LEN_LO;
              end else begin
                phase_d = hunt_next(b, preamble_q);
              end
            end
            PH_LEN_LO: begin
              held_len_lo_d = b;
              phase_d       = PH_LEN_HI;
            end
            default: phase_d = hunt_next(b, preamble_q);
          endcase
        end else if (len == '0) begin
          phase_d     = PH_HUNT;
          res_load    = 1'b1;
          res_byte_d  = '0;
          res_first_d = 1'b0;
          res_last_d  = 1'b1;
          res_empty_d = 1'b1;
        end else begin
          remaining_d = len[LEN_W-1:0];
          at_first_d  = 1'b1;
          phase_d     = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        if (remaining_q == '0) begin
          phase_d = hunt_next(b, preamble_q);
        end else begin
          res_load    = 1'b1;
          res_byte_d  = b;
          res_first_d = at_first_q;
          res_last_d  = (remaining_q == LEN_W'(1));
          res_empty_d = 1'b0;
          remaining_d = remaining_q - LEN_W'(1);
          at_first_d  = 1'b0;
          if (remaining_q == LEN_W'(1)) begin
            phase_d    = PH_HUNT;
            at_first_d = 1'b1;
          end
        end
      end
      default: phase_d = hunt_next(b, preamble_q);
    endcase
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (res_o.ready) begin
      res_valid_d = 1'b0;
    end
    if (rx_req && res_load) begin
      res_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_HUNT;
      held_type_q   <= '0;
      held_len_lo_q <= '0;
      remaining_q   <= '0;
      at_first_q    <= 1'b1;
      res_valid_q   <= 1'b0;
      res_byte_q    <= '0;
      res_first_q   <= 1'b0;
      res_last_q    <= 1'b0;
      res_empty_q   <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
      if (rx_req) begin
        phase_q       <= phase_d;
        held_type_q   <= held_type_d;
        held_len_lo_q <= held_len_lo_d;
        remaining_q   <= remaining_d;
        at_first_q    <= at_first_d;
        if (res_load) begin
          res_byte_q  <= res_byte_d;
          res_first_q <= res_first_d;
          res_last_q  <= res_last_d;
          res_empty_q <= res_empty_d;
        end
      end
    end
  end

  assign res_o.valid           = res_valid_q;
  assign res_o.payload_byte    = res_byte_q;
  assign res_o.first_of_packet = res_first_q;
  assign res_o.last_of_packet  = res_last_q;
  assign res_o.empty_packet    = res_empty_q;

  `PLPD_ASSERT(a_empty_shape, res_valid_q && res_empty_q |-> res_last_q && !res_first_q && res_byte_q == '0, "empty packet result malformed")
  `PLPD_ASSERT(a_payload_count, phase_q == PH_PAYLOAD |-> remaining_q != '0, "payload phase with no bytes left")
  `PLPD_ASSERT(a_last_ends, rx_req && phase_q == PH_PAYLOAD && remaining_q == LEN_W'(1) |=> phase_q == PH_HUNT && res_valid_q && res_last_q, "last payload byte did not end packet")
  `PLPD_ASSERT(a_no_overrun, res_valid_q && !res_o.ready |-> !rx_i.ready, "byte taken while result stalled")

endmodule
